/* rtl/imugc_pkg.sv */
// ----------------------------------------------------------------------------
// imugc_pkg
// Shared constants, widths and the sine table generator for the IMU gravity
// compensation and velocity integrator.
// ----------------------------------------------------------------------------
package imugc_pkg;

  // sine table size and heading wrap detection
  localparam int SINE_TABLE_ENTRIES = 1024;
  localparam int WRAP_THRESHOLD     = 3040;

  // angles in 1/16 degree
  localparam int FULL_TURN    = 5760;
  localparam int QUARTER_TURN = 1440;
  localparam int ANGLE_W      = 13;

  localparam longint unsigned PI_Q30 = 64'd3373259426;

  // sine values are Q14, 16384 is one
  localparam int SINE_W     = 16;
  localparam int SINE_IDX_W = $clog2(SINE_TABLE_ENTRIES);

  // index = (u * N + FULL_TURN / 2) / FULL_TURN by reciprocal multiply
  localparam longint NUM_MAX     = longint'(FULL_TURN - 1) * SINE_TABLE_ENTRIES
                                   + FULL_TURN / 2;
  localparam int     NUM_W       = $clog2(NUM_MAX + 1);
  localparam int     RECIP_SHIFT = NUM_W + 13;
  localparam longint unsigned RECIP = ((64'd1 << RECIP_SHIFT) + FULL_TURN - 1)
                                      / FULL_TURN;
  localparam int     RECIP_W     = $clog2(RECIP + 1);

  typedef logic signed [SINE_W-1:0] sine_rom_t [SINE_TABLE_ENTRIES];

  // one full turn of sine, built with the same integer series as the testbench checker
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t       rom;
    longint unsigned th;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned prd;
    longint          acc;
    longint          q;
    logic            neg;
    for (int k = 0; k < SINE_TABLE_ENTRIES; k++) begin
      th  = (64'd2 * PI_Q30 * longint'(k)) / SINE_TABLE_ENTRIES;
      neg = 1'b0;
      if (th > PI_Q30) begin
        th  = th - PI_Q30;
        neg = 1'b1;
      end
      if (th > PI_Q30 / 2) begin
        th = PI_Q30 - th;
      end
      x2   = (th * th) >> 30;
      term = th;
      acc  = longint'(th);
      for (int n = 1; n <= 5; n++) begin
        prd = (term * x2) >> 30;
        case (n)
          1:       term = prd / 6;
          2:       term = prd / 20;
          3:       term = prd / 42;
          4:       term = prd / 72;
          default: term = prd / 110;
        endcase
        if (n % 2 == 1) begin
          acc = acc - longint'(term);
        end else begin
          acc = acc + longint'(term);
        end
      end
      if (acc < 0) begin
        acc = 0;
      end
      q = (acc + 32768) >>> 16;
      if (q > 16384) begin
        q = 16384;
      end
      if (neg) begin
        q = -q;
      end
      rom[k] = SINE_W'(q);
    end
    return rom;
  endfunction

endpackage

/* rtl/imu_gravity_comp_velocity_integrator_unit.sv */
// ----------------------------------------------------------------------------
// imu_gravity_comp_velocity_integrator_unit
// Gravity removal, dead-band velocity integration and heading unwrap for one
// IMU sample per transfer.
// ----------------------------------------------------------------------------
// A small sequencer drives a single signed multiplier. Each of the four angle
// lookups (sin and cos of pitch and roll) runs two multiplies on the table
// index, then addresses the sine ROM and loads its registered data. Seven
// gravity and integration products, the revolution scaling and the load of
// the output register follow. The result sits in an output register, so a
// new sample is taken while the previous result still waits for out_tready;
// a second finished result holds the sequencer, and with it in_tready, until
// that register drains. Register writes on the cfg_ channel take effect at
// once, so they belong between samples, while no sample is in flight.
module imu_gravity_comp_velocity_integrator_unit import imugc_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  // input samples
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [87:0]  in_tdata,   // acc_x, acc_y, acc_z, pitch, roll, heading
  // results
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // vel_x, vel_y, vel_z, heading_unwrapped
  // register writes
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [11:0]  cfg_data
);

  typedef enum logic [1:0] {
    REG_DEAD_BAND = 2'd0,
    REG_GRAVITY   = 2'd1,
    REG_PERIOD    = 2'd2,
    REG_UNUSED    = 2'd3
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NUM,
    ST_DIV,
    ST_ADDR,
    ST_LOAD,
    ST_GX,
    ST_GY,
    ST_CC,
    ST_CCG,
    ST_PX,
    ST_PY,
    ST_PZ,
    ST_REV,
    ST_OUT
  } state_t;

  localparam int MA_W  = (NUM_W + 1 > 30) ? NUM_W + 1 : 30;
  localparam int MB_W  = (RECIP_W + 1 > SINE_W) ? RECIP_W + 1 : SINE_W;
  localparam int P_W   = MA_W + MB_W;
  localparam int RES_W = 18;
  localparam int GT_W  = 12;
  localparam int CC_W  = 30;
  localparam int SUM_W = 34;
  localparam int HU_W  = 29;

  localparam logic signed [31:0] VEL_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] VEL_MIN = 32'sh8000_0000;
  localparam logic signed [15:0] REV_MAX = 16'sh7fff;
  localparam logic signed [15:0] REV_MIN = 16'sh8000;

  state_t state_r;
  logic [1:0] ang_r;

  // configuration
  logic [11:0] dead_band_r;
  logic [10:0] gravity_r;
  logic [9:0]  period_r;

  // captured sample
  logic signed [15:0]        acc_r [3];
  logic signed [ANGLE_W-1:0] pitch_r;
  logic signed [ANGLE_W-1:0] roll_r;
  logic [ANGLE_W-1:0]        head_r;

  // working values
  logic signed [SINE_W-1:0] trig_r [4];
  logic signed [RES_W-1:0]  res_r [3];
  logic signed [P_W-1:0]    prod_r;

  // persistent state
  logic signed [31:0]   vel_r [3];
  logic [ANGLE_W-1:0]   prev_head_r;
  logic signed [15:0]   rev_r;

  logic                 out_tvalid_r;
  logic [127:0]         out_tdata_r;

  // shared multiplier
  logic signed [MA_W-1:0] mul_a;
  logic signed [MB_W-1:0] mul_b;
  logic signed [P_W-1:0]  prod_nxt;

  // angle to table index
  logic signed [ANGLE_W-1:0] ang_sel;
  logic signed [ANGLE_W:0]   ang_ext;
  logic [ANGLE_W-1:0]        ang_u;
  logic [NUM_W-1:0]          num;
  logic [SINE_IDX_W:0]       idx_full;
  logic [SINE_IDX_W-1:0]     rom_addr;
  logic signed [SINE_W-1:0]  rom_data;

  // rounded gravity terms
  logic signed [P_W-1:0]  bias14;
  logic signed [P_W-1:0]  bias28;
  logic signed [P_W-1:0]  sum14;
  logic signed [P_W-1:0]  sum28;
  logic signed [GT_W-1:0] gterm14;
  logic signed [GT_W-1:0] gterm28;

  logic signed [ANGLE_W:0] dhead;
  logic signed [15:0]      rev_nxt;
  logic signed [31:0]      vel_nxt;
  logic [1:0]              vel_sel;
  logic [HU_W-1:0]         unwrapped;
  logic                    in_xfer;

  function automatic logic signed [31:0] vel_update(
    input logic signed [31:0]      vel,
    input logic signed [RES_W-1:0] res,
    input logic signed [P_W-1:0]   inc,
    input logic [11:0]             band
  );
    logic [RES_W-1:0]        mag;
    logic signed [SUM_W-1:0] acc;
    logic signed [31:0]      v;
    mag = res[RES_W-1] ? RES_W'(-res) : RES_W'(res);
    acc = SUM_W'(vel) + SUM_W'(inc);
    if (mag <= RES_W'(band)) begin
      v = '0;
    end else if (!acc[SUM_W-1] && (|acc[SUM_W-2:31])) begin
      v = VEL_MAX;
    end else if (acc[SUM_W-1] && !(&acc[SUM_W-2:31])) begin
      v = VEL_MIN;
    end else begin
      v = acc[31:0];
    end
    return v;
  endfunction

  imugc_sine_rom u_sine_rom (
    .clk    (clk),
    .addr   (rom_addr),
    .data_r (rom_data)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // angle of the current lookup, cos taken as sin a quarter turn on
  always_comb begin
    ang_sel = ang_r[0] ? roll_r : pitch_r;
    ang_ext = (ANGLE_W + 1)'(ang_sel) + (ang_r[1] ? (ANGLE_W + 1)'(QUARTER_TURN) : '0);
    if (ang_ext[ANGLE_W]) begin
      ang_u = ANGLE_W'(ang_ext + (ANGLE_W + 1)'(FULL_TURN));
    end else begin
      ang_u = ANGLE_W'(ang_ext);
    end
    num      = prod_r[NUM_W-1:0] + NUM_W'(FULL_TURN / 2);
    idx_full = prod_r[RECIP_SHIFT +: SINE_IDX_W + 1];
    if (idx_full >= (SINE_IDX_W + 1)'(SINE_TABLE_ENTRIES)) begin
      rom_addr = SINE_IDX_W'(idx_full - (SINE_IDX_W + 1)'(SINE_TABLE_ENTRIES));
    end else begin
      rom_addr = idx_full[SINE_IDX_W-1:0];
    end
  end

  // round half away from zero
  always_comb begin
    bias14  = prod_r[P_W-1] ? P_W'((1 << 13) - 1) : P_W'(1 << 13);
    bias28  = prod_r[P_W-1] ? P_W'((1 << 27) - 1) : P_W'(1 << 27);
    sum14   = prod_r + bias14;
    sum28   = prod_r + bias28;
    gterm14 = GT_W'(sum14 >>> 14);
    gterm28 = GT_W'(sum28 >>> 28);
  end

  // multiplier operands per step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_NUM: begin
        mul_a = MA_W'(ang_u);
        mul_b = MB_W'(SINE_TABLE_ENTRIES);
      end
      ST_DIV: begin
        mul_a = MA_W'(num);
        mul_b = MB_W'(RECIP);
      end
      ST_GX: begin
        mul_a = MA_W'(trig_r[0]);
        mul_b = MB_W'(gravity_r);
      end
      ST_GY: begin
        mul_a = MA_W'(trig_r[1]);
        mul_b = MB_W'(gravity_r);
      end
      ST_CC: begin
        mul_a = MA_W'(trig_r[2]);
        mul_b = MB_W'(trig_r[3]);
      end
      ST_CCG: begin
        mul_a = MA_W'($signed(prod_r[CC_W-1:0]));
        mul_b = MB_W'(gravity_r);
      end
      ST_PX: begin
        mul_a = MA_W'(res_r[0]);
        mul_b = MB_W'(period_r);
      end
      ST_PY: begin
        mul_a = MA_W'(res_r[1]);
        mul_b = MB_W'(period_r);
      end
      ST_PZ: begin
        mul_a = MA_W'(res_r[2]);
        mul_b = MB_W'(period_r);
      end
      ST_REV: begin
        mul_a = MA_W'(rev_r);
        mul_b = MB_W'(FULL_TURN);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_nxt = P_W'(mul_a) * P_W'(mul_b);
  end

  // heading wrap and velocity step
  always_comb begin
    dhead   = $signed({1'b0, prev_head_r}) - $signed({1'b0, head_r});
    rev_nxt = rev_r;
    if (dhead > $signed((ANGLE_W + 1)'(WRAP_THRESHOLD))) begin
      if (rev_r != REV_MAX) begin
        rev_nxt = rev_r + 16'sd1;
      end
    end else if (dhead < -$signed((ANGLE_W + 1)'(WRAP_THRESHOLD))) begin
      if (rev_r != REV_MIN) begin
        rev_nxt = rev_r - 16'sd1;
      end
    end
    case (state_r)
      ST_PZ:   vel_sel = 2'd1;
      ST_REV:  vel_sel = 2'd2;
      default: vel_sel = 2'd0;
    endcase
    vel_nxt   = vel_update(vel_r[vel_sel], res_r[vel_sel], prod_r, dead_band_r);
    unwrapped = HU_W'(head_r) + prod_r[HU_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      ang_r        <= '0;
      dead_band_r  <= 12'd20;
      gravity_r    <= 11'd981;
      period_r     <= 10'd50;
      vel_r[0]     <= '0;
      vel_r[1]     <= '0;
      vel_r[2]     <= '0;
      prev_head_r  <= '0;
      rev_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_DEAD_BAND: dead_band_r <= cfg_data;
          REG_GRAVITY:   gravity_r   <= cfg_data[10:0];
          REG_PERIOD:    period_r    <= cfg_data[9:0];
          default:       ;
        endcase
      end

      // output register loads from ST_OUT once it is free or draining
      if (state_r == ST_OUT && (!out_tvalid_r || out_tready)) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end

      if (state_r != ST_OUT) begin
        prod_r <= prod_nxt;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            acc_r[0] <= in_tdata[15:0];
            acc_r[1] <= in_tdata[31:16];
            acc_r[2] <= in_tdata[47:32];
            pitch_r  <= in_tdata[60:48];
            roll_r   <= in_tdata[73:61];
            head_r   <= in_tdata[86:74];
            ang_r    <= '0;
            state_r  <= ST_NUM;
          end
        end
        ST_NUM:  state_r <= ST_DIV;
        ST_DIV:  state_r <= ST_ADDR;
        ST_ADDR: state_r <= ST_LOAD;
        ST_LOAD: begin
          trig_r[ang_r] <= rom_data;
          if (ang_r == 2'd3) begin
            state_r <= ST_GX;
          end else begin
            ang_r   <= ang_r + 2'd1;
            state_r <= ST_NUM;
          end
        end
        ST_GX: begin
          rev_r       <= rev_nxt;
          prev_head_r <= head_r;
          state_r     <= ST_GY;
        end
        ST_GY: begin
          res_r[0] <= RES_W'(acc_r[0]) - RES_W'(gterm14);
          state_r  <= ST_CC;
        end
        ST_CC: begin
          res_r[1] <= RES_W'(acc_r[1]) + RES_W'(gterm14);
          state_r  <= ST_CCG;
        end
        ST_CCG: state_r <= ST_PX;
        ST_PX: begin
          res_r[2] <= RES_W'(acc_r[2]) - RES_W'(gterm28);
          state_r  <= ST_PY;
        end
        ST_PY: begin
          vel_r[0] <= vel_nxt;
          state_r  <= ST_PZ;
        end
        ST_PZ: begin
          vel_r[1] <= vel_nxt;
          state_r  <= ST_REV;
        end
        ST_REV: begin
          vel_r[2] <= vel_nxt;
          state_r  <= ST_OUT;
        end
        ST_OUT: begin
          // wait for the output register to drain
          if (!out_tvalid_r || out_tready) begin
            out_tdata_r  <= {3'b000, unwrapped, vel_r[2], vel_r[1], vel_r[0]};
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

/* rtl/imugc_sine_rom.sv */
// ----------------------------------------------------------------------------
// imugc_sine_rom
// Full-turn Q14 sine lookup with registered read data.
// ----------------------------------------------------------------------------
module imugc_sine_rom import imugc_pkg::*; (
  input  logic                     clk,
  input  logic [SINE_IDX_W-1:0]    addr,
  output logic signed [SINE_W-1:0] data_r
);

  localparam sine_rom_t ROM = build_sine_rom();

  always_ff @(posedge clk) begin
    data_r <= ROM[addr];
  end

endmodule

/* tb/sv/imugc_tb_pkg.sv */
// ----------------------------------------------------------------------------
// imugc_tb_pkg
// Register codes and packed sample and result layouts shared by the IMU
// integrator testbench top and its checker.
// ----------------------------------------------------------------------------
package imugc_tb_pkg;

  typedef enum logic [1:0] {
    REG_DEAD_BAND     = 2'd0,
    REG_GRAVITY_VALUE = 2'd1,
    REG_PERIOD_MS     = 2'd2,
    REG_UNMAPPED      = 2'd3
  } cfg_reg_e;

  // in_tdata[86:0], acc_x in the lowest bits
  typedef struct packed {
    logic        [12:0] heading;
    logic signed [12:0] roll;
    logic signed [12:0] pitch;
    logic signed [15:0] acc_z;
    logic signed [15:0] acc_y;
    logic signed [15:0] acc_x;
  } imu_sample_t;

  // out_tdata[124:0], vel_x in the lowest bits
  typedef struct packed {
    logic signed [28:0] heading_unwrapped;
    logic signed [31:0] vel_z;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_x;
  } velocity_result_t;

endpackage

/* tb/sv/imugc_velocity_checker.sv */
// ----------------------------------------------------------------------------
// imugc_velocity_checker
// Watches the sample, result and register channels of the IMU integrator,
// keeps its own copy of the registers, velocities and revolution count,
// predicts each result and compares it field by field in arrival order.
// ----------------------------------------------------------------------------
module imugc_velocity_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [87:0]  in_tdata,   // acc_x, acc_y, acc_z, pitch, roll, heading
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [127:0] out_tdata,  // vel_x, vel_y, vel_z, heading_unwrapped
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [11:0]  cfg_data,
  output int           mismatch_count,
  output int           results_pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import imugc_tb_pkg::*;

  localparam int              TABLE_SIZE = 1024;
  localparam int              JUMP_LIMIT = 3040;
  localparam int              TURN       = 5760;
  localparam int              QUARTER    = 1440;
  localparam longint unsigned PI_Q30     = 64'd3373259426;
  localparam longint          VEL_MAX    = (longint'(1) << 31) - 1;
  localparam longint          VEL_MIN    = -(longint'(1) << 31);

  int               sine_tab [TABLE_SIZE];

  logic [11:0]      dead_band;
  logic [10:0]      gravity;
  logic [9:0]       period;
  int               vel_x;
  int               vel_y;
  int               vel_z;
  logic [12:0]      last_heading;
  shortint          turns;
  velocity_result_t expected_q [$];
  int               errors = 0;

  // Q14 sine over one full turn, Q30 odd series folded into the first quadrant
  initial begin : build_sine
    longint unsigned th;
    longint unsigned x2;
    longint unsigned term;
    longint          acc;
    longint          q;
    bit              neg;
    for (int k = 0; k < TABLE_SIZE; k++) begin
      th  = (64'd2 * PI_Q30 * 64'(k)) / 64'(TABLE_SIZE);
      neg = 1'b0;
      if (th > PI_Q30) begin
        th  = th - PI_Q30;
        neg = 1'b1;
      end
      if (th > PI_Q30 / 2) th = PI_Q30 - th;
      x2   = (th * th) >> 30;
      term = th;
      acc  = longint'(th);
      for (int n = 1; n <= 5; n++) begin
        term = ((term * x2) >> 30) / 64'(4 * n * n + 2 * n);
        if (n % 2 == 1) acc = acc - longint'(term);
        else acc = acc + longint'(term);
      end
      if (acc < 0) acc = 0;
      q = (acc + 32768) >>> 16;
      if (q > 16384) q = 16384;
      sine_tab[k] = neg ? -int'(q) : int'(q);
    end
  end

  function automatic longint sine_at(input int angle);
    int u;
    int idx;
    u = angle % TURN;
    if (u < 0) u += TURN;
    idx = (u * TABLE_SIZE + TURN / 2) / TURN;
    if (idx >= TABLE_SIZE) idx -= TABLE_SIZE;
    return longint'(sine_tab[idx]);
  endfunction

  // half away from zero
  function automatic longint round_away(input longint v, input int sh);
    longint half;
    half = longint'(1) << (sh - 1);
    if (v >= 0) return (v + half) >>> sh;
    return -((-v + half) >>> sh);
  endfunction

  function automatic int integrate_axis(input int vel, input longint resid);
    longint mag;
    longint sum;
    mag = (resid < 0) ? -resid : resid;
    if (mag <= longint'(dead_band)) return 0;
    sum = longint'(vel) + resid * longint'(period);
    if (sum > VEL_MAX) sum = VEL_MAX;
    if (sum < VEL_MIN) sum = VEL_MIN;
    return int'(sum);
  endfunction

  task automatic predict_sample(input imu_sample_t s);
    longint           g;
    longint           sp;
    longint           sr;
    longint           cp;
    longint           cr;
    int               d;
    velocity_result_t r;
    g  = longint'(gravity);
    sp = sine_at(int'(s.pitch));
    sr = sine_at(int'(s.roll));
    cp = sine_at(int'(s.pitch) + QUARTER);
    cr = sine_at(int'(s.roll) + QUARTER);
    vel_x = integrate_axis(vel_x, longint'(s.acc_x) - round_away(sp * g, 14));
    vel_y = integrate_axis(vel_y, longint'(s.acc_y) + round_away(sr * g, 14));
    vel_z = integrate_axis(vel_z, longint'(s.acc_z) - round_away(cp * cr * g, 28));
    // jump backwards across north counts a turn up, forwards counts down
    d = int'(last_heading) - int'(s.heading);
    if (d > JUMP_LIMIT) begin
      if (turns < 32767) turns = turns + 1;
    end else if (d < -JUMP_LIMIT) begin
      if (turns > -32768) turns = turns - 1;
    end
    last_heading = s.heading;
    r.vel_x = vel_x;
    r.vel_y = vel_y;
    r.vel_z = vel_z;
    r.heading_unwrapped = 29'(longint'(s.heading) + longint'(turns) * TURN);
    expected_q.push_back(r);
  endtask

  task automatic flag_field(input string field, input longint want, input longint got);
    errors++;
    if (errors <= 10) $display("mismatch on %s: expected %0d, got %0d", field, want, got);
  endtask

  always @(posedge clk) begin : monitor
    velocity_result_t got;
    velocity_result_t want;
    if (!rst_n) begin
      dead_band    = 12'd20;
      gravity      = 11'd981;
      period       = 10'd50;
      vel_x        = 0;
      vel_y        = 0;
      vel_z        = 0;
      last_heading = '0;
      turns        = 0;
      expected_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got = velocity_result_t'(out_tdata[124:0]);
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("result transfer with no sample pending: %h", got);
        end else begin
          want = expected_q.pop_front();
          if (got.vel_x !== want.vel_x) flag_field("vel_x", want.vel_x, got.vel_x);
          if (got.vel_y !== want.vel_y) flag_field("vel_y", want.vel_y, got.vel_y);
          if (got.vel_z !== want.vel_z) flag_field("vel_z", want.vel_z, got.vel_z);
          if (got.heading_unwrapped !== want.heading_unwrapped)
            flag_field("heading_unwrapped", want.heading_unwrapped, got.heading_unwrapped);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_e'(cfg_index))
          REG_DEAD_BAND:     dead_band = cfg_data;
          REG_GRAVITY_VALUE: gravity = cfg_data[10:0];
          REG_PERIOD_MS:     period = cfg_data[9:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) predict_sample(imu_sample_t'(in_tdata[86:0]));
    end
    mismatch_count  <= errors;
    results_pending <= expected_q.size();
  end

endmodule

/* tb/sv/tb_imu_gravity_comp_velocity_integrator_unit.sv */
// ----------------------------------------------------------------------------
// tb_imu_gravity_comp_velocity_integrator_unit
// Drives IMU samples and register writes into the integrator with random
// pacing on both streams. A short directed set hits the dead band edges,
// heading jumps and field extremes; random bursts of level, tilted, pushed
// and raw samples follow under several register settings.
// ----------------------------------------------------------------------------
module tb_imu_gravity_comp_velocity_integrator_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import imugc_tb_pkg::*;

  typedef enum int {BURST_NOISE, BURST_LEVEL, BURST_PUSH, BURST_TILT} burst_e;

  localparam int PHASE_COUNT = 8;
  localparam int PHASE_ITEMS = 250;

  logic         clk = 1'b0;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [87:0]  in_tdata;   // acc_x, acc_y, acc_z, pitch, roll, heading
  logic         out_tvalid;
  logic         out_tready;
  logic [127:0] out_tdata;  // vel_x, vel_y, vel_z, heading_unwrapped
  logic         cfg_valid;
  logic         cfg_ready;
  logic [1:0]   cfg_index;
  logic [11:0]  cfg_data;
  int           mismatch_count;
  int           results_pending;
  int           walk_heading;

  always #5 clk = ~clk;

  imu_gravity_comp_velocity_integrator_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  imugc_velocity_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatch_count  (mismatch_count),
    .results_pending (results_pending)
  );

  function automatic imu_sample_t mk_sample(input int ax, input int ay, input int az,
                                            input int p, input int r, input int h);
    imu_sample_t s;
    s.acc_x   = 16'(ax);
    s.acc_y   = 16'(ay);
    s.acc_z   = 16'(az);
    s.pitch   = 13'(p);
    s.roll    = 13'(r);
    s.heading = 13'(h);
    return s;
  endfunction

  function automatic int rand_span(input int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic imu_sample_t next_sample(input burst_e kind, input int push_sign);
    imu_sample_t s;
    int          span;
    // heading drifts and crosses north now and then
    walk_heading = walk_heading + rand_span(300);
    if ($urandom_range(0, 15) == 0) walk_heading = int'($urandom_range(0, 5759));
    if (walk_heading < 0) walk_heading += 5760;
    else if (walk_heading >= 5760) walk_heading -= 5760;
    case (kind)
      BURST_NOISE: s = imu_sample_t'(87'({$urandom(), $urandom(), $urandom()}));
      BURST_LEVEL: begin
        span = ($urandom_range(0, 3) == 0) ? 2000 : 60;
        s = mk_sample(rand_span(span), rand_span(span), 981 + rand_span(span),
                      rand_span(200), rand_span(200), walk_heading);
      end
      BURST_PUSH: begin
        // same sign on every axis for a long run drives the velocities toward the rails
        s = mk_sample(push_sign * int'($urandom_range(20000, 32767)),
                      push_sign * int'($urandom_range(20000, 32767)),
                      push_sign * int'($urandom_range(20000, 32767)),
                      rand_span(2880), rand_span(2880), walk_heading);
      end
      default: begin
        s = mk_sample(rand_span(4000), rand_span(4000), rand_span(4000),
                      rand_span(2880), rand_span(2880), walk_heading);
      end
    endcase
    return s;
  endfunction

  task automatic send_sample(input imu_sample_t s, input bit paced);
    int gap;
    gap = paced ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, s};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [11:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // registers only change once every result has drained
  task automatic set_config(input logic [11:0] db, input logic [11:0] grav,
                            input logic [11:0] per, input bit poke_unmapped);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    write_reg(REG_DEAD_BAND, db);
    write_reg(REG_GRAVITY_VALUE, grav);
    write_reg(REG_PERIOD_MS, per);
    if (poke_unmapped) write_reg(REG_UNMAPPED, 12'hfff);
    cfg_valid <= 1'b0;
  endtask

  initial begin : result_sink
    int stall;
    int taken;
    bit paced;
    out_tready <= 1'b0;
    taken = 0;
    paced = 1'b1;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (taken % 64 == 0) paced = $urandom_range(0, 2) != 0;
      stall = paced ? $urandom_range(0, 4) : 0;
      // long hold so the output register fills and in_tready backs up
      if (taken == 150 || taken == 1100) stall += 400;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      taken++;
    end
  end

  initial begin : stimulus
    burst_e kind;
    int     burst_left;
    int     push_sign;
    int     r;
    bit     paced;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_DEAD_BAND;
    cfg_data  <= '0;
    walk_heading = 0;
    kind         = BURST_LEVEL;
    burst_left   = 0;
    push_sign    = 1;
    paced        = 1'b1;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // first heading above the jump limit counts a turn down
    send_sample(mk_sample(0, 0, 0, 0, 0, 5759), 1'b1);
    // dead band edges with level attitude, heading steps right at the limit
    send_sample(mk_sample(20, -20, 1001, 0, 0, 2719), 1'b1);
    send_sample(mk_sample(21, -21, 1002, 0, 0, 5759), 1'b1);
    send_sample(mk_sample(-20, 20, 961, 0, 0, 2718), 1'b1);
    send_sample(mk_sample(-21, 21, 960, 0, 0, 5759), 1'b1);
    // field extremes and angles past the nominal range
    send_sample(mk_sample(32767, -32768, 32767, 2880, -2880, 0), 1'b1);
    send_sample(mk_sample(-32768, 32767, -32768, -2880, 2880, 8191), 1'b1);
    send_sample(mk_sample(32767, 32767, 32767, 4095, -4096, 0), 1'b1);
    send_sample(mk_sample(-32768, -32768, -32768, -4096, 4095, 4000), 1'b1);
    send_sample(mk_sample(0, 0, 0, 1440, -1440, 1000), 1'b1);
    send_sample(mk_sample(500, -500, 0, 720, 2160, 100), 1'b1);

    set_config(12'd0, 12'd2047, 12'd1000, 1'b0);
    send_sample(mk_sample(0, 0, 2047, 0, 0, 200), 1'b1);
    send_sample(mk_sample(1, -1, 2048, 0, 0, 300), 1'b1);
    send_sample(mk_sample(32767, 32767, -32768, 2880, 2880, 5000), 1'b1);

    // zero period holds velocities outside the dead band, unmapped index must change nothing
    set_config(12'd4095, 12'd0, 12'd0, 1'b1);
    send_sample(mk_sample(4095, -4095, 4095, 100, 100, 6000), 1'b1);
    send_sample(mk_sample(4096, -4096, -4096, -100, 300, 1200), 1'b1);

    // upper data bits beyond the register widths are dropped
    set_config(12'd1, 12'hfff, 12'hfff, 1'b0);
    send_sample(mk_sample(3000, -3000, 3000, 2880, 0, 5759), 1'b1);
    send_sample(mk_sample(3000, -3000, 3000, 0, -2880, 2), 1'b1);
    send_sample(mk_sample(-2, 2, 2047, 0, 0, 3043), 1'b1);
    send_sample(mk_sample(2, -2, 2046, 0, 0, 2), 1'b1);

    for (int p = 0; p < PHASE_COUNT; p++) begin
      case (p)
        0:       set_config(12'd20, 12'd981, 12'd50, 1'b0);
        1:       set_config(12'd0, 12'd2047, 12'd1000, 1'b0);
        2:       set_config(12'd4095, 12'd0, 12'd1, 1'b0);
        3:       set_config(12'd5, 12'd981, 12'd1023, 1'b0);
        4:       set_config(12'd100, 12'd1500, 12'd0, 1'b0);
        default: set_config(12'($urandom), 12'($urandom), 12'($urandom), 1'b0);
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (burst_left == 0) begin
          r = $urandom_range(0, 9);
          if (r < 2) kind = BURST_NOISE;
          else if (r < 6) kind = BURST_LEVEL;
          else if (r < 8) kind = BURST_PUSH;
          else kind = BURST_TILT;
          if (kind == BURST_PUSH) burst_left = $urandom_range(60, 120);
          else burst_left = $urandom_range(1, 30);
          paced     = $urandom_range(0, 3) != 0;
          push_sign = ($urandom_range(0, 1) == 1) ? 1 : -1;
        end
        send_sample(next_sample(kind, push_sign), paced);
        burst_left--;
      end
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : watchdog
    #5ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule

/* files.f */
rtl/imugc_pkg.sv
rtl/imugc_sine_rom.sv
rtl/imu_gravity_comp_velocity_integrator_unit.sv
tb/sv/imugc_tb_pkg.sv
tb/sv/imugc_velocity_checker.sv
tb/sv/tb_imu_gravity_comp_velocity_integrator_unit.sv
